@@ hw/rtl/rad_pkg.sv @@
// ============================================================================
// Resource archive directory check package
// Shared constants, verdict codes and byte helpers for the directory checker.
// ============================================================================
`default_nettype none

package rad_pkg;

	localparam int unsigned HdrLen   = 6;
	localparam int unsigned RecLen   = 21;
	localparam int unsigned NameLen  = 13;
	localparam int unsigned MinTotal = HdrLen + RecLen;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_TOO_SMALL  = 4'd1,
		ST_MAGIC      = 4'd2,
		ST_COUNT      = 4'd3,
		ST_DIR_RANGE  = 4'd4,
		ST_NEGATIVE   = 4'd5,
		ST_NAME       = 4'd6,
		ST_FIRST_OFS  = 4'd7,
		ST_OFS_LOW    = 4'd8,
		ST_MEMBER_RNG = 4'd9
	} status_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0: m = 8'h4b;
			2'd1: m = 8'h52;
			2'd2: m = 8'h4d;
			2'd3: m = 8'h4c;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic char_ok(input logic [7:0] c);
		logic ok;
		ok = (c >= 8'h20) && (c <= 8'h7e);
		if (c inside {8'h22, 8'h2a, 8'h3c, 8'h3e, 8'h3f, 8'h7c, 8'h3a, 8'h5c, 8'h2f})
			ok = 1'b0;
		return ok;
	endfunction

	function automatic logic [20:0] times_rec_len(input logic [15:0] n);
		logic [20:0] w;
		w = {5'd0, n};
		return (w << 4) + (w << 2) + w;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/resource_archive_directory_check.sv @@
// ============================================================================
// Resource archive directory check
// Checks the header and directory records of a resource archive one byte per
// beat and delivers a single verdict with the archive size.
// ============================================================================
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------------
//  byte      | byte_valid, byte_stall    | data_byte, start_of_file
//  verdict   | verdict_valid,verdict_stall| status, archive_size, member_count,
//            |                           | directory_bytes
//  config    | cfg_write_en              | cfg_write_data
//
// One byte is taken per cycle while byte_stall is low. A byte is registered at
// acceptance and judged from the input register, and its verdict is registered.
// Reset clears all control state; no verdict is pending after reset.
// A stalled verdict holds the next byte in the input register, and the byte
// channel stalls only while both registers are occupied.
`default_nettype none

module resource_archive_directory_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [31:0] cfg_write_data,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_of_file,
	output logic             verdict_valid,
	input  wire logic        verdict_stall,
	output logic [3:0]       status,
	output logic [31:0]      archive_size,
	output logic [15:0]      member_count,
	output logic [20:0]      directory_bytes
);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DIR    = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	logic [31:0] total_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        advance;
	logic        take;

	phase_t      phase_q, phase_n;
	logic [4:0]  pos_q, pos_n;
	logic [15:0] rec_q, rec_n;
	logic [15:0] count_q, count_n;
	logic [20:0] das_q, das_n;
	logic [31:0] ofs_q, ofs_n;
	logic [31:0] size_q, size_n;
	logic [3:0]  name_len_q, name_len_n;
	logic        name_end_q, name_end_n;
	logic        name_bad_q, name_bad_n;
	logic [31:0] largest_q, largest_n;

	logic              fire;
	rad_pkg::status_t  res_st;
	logic              work;
	logic [15:0]       cnt_v;
	logic [20:0]       dir_end;
	logic [1:0]        lane;
	logic [31:0]       mem_end;

	assign advance    = !verdict_valid || !verdict_stall;
	assign byte_stall = valid_s1 && !advance;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_write_en) begin
			total_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1  <= data_byte;
			start_s1 <= start_of_file;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		pos_n      = pos_q;
		rec_n      = rec_q;
		count_n    = count_q;
		das_n      = das_q;
		ofs_n      = ofs_q;
		size_n     = size_q;
		name_len_n = name_len_q;
		name_end_n = name_end_q;
		name_bad_n = name_bad_q;
		largest_n  = largest_q;
		fire       = 1'b0;
		res_st     = rad_pkg::ST_OK;
		work       = 1'b0;
		cnt_v      = '0;
		dir_end    = '0;
		lane       = '0;
		mem_end    = '0;

		if (start_s1) begin
			phase_n    = PH_HEADER;
			pos_n      = '0;
			rec_n      = '0;
			count_n    = '0;
			das_n      = '0;
			largest_n  = '0;
			ofs_n      = '0;
			size_n     = '0;
			name_len_n = '0;
			name_end_n = 1'b0;
			name_bad_n = 1'b0;
			work       = 1'b1;
			if (total_q < 32'(rad_pkg::MinTotal)) begin
				fire   = 1'b1;
				res_st = rad_pkg::ST_TOO_SMALL;
			end
		end else if (phase_q == PH_HEADER || phase_q == PH_DIR) begin
			work = 1'b1;
		end

		if (work && !fire) begin
			case (phase_n)
				PH_HEADER: begin
					if (pos_n < 5'd4) begin
						if (byte_s1 != rad_pkg::magic_byte(pos_n[1:0])) begin
							fire   = 1'b1;
							res_st = rad_pkg::ST_MAGIC;
						end else begin
							pos_n = pos_n + 5'd1;
						end
					end else if (pos_n == 5'd4) begin
						count_n = {8'd0, byte_s1};
						pos_n   = 5'd5;
					end else begin
						cnt_v   = {byte_s1, count_n[7:0]};
						count_n = cnt_v;
						dir_end = rad_pkg::times_rec_len(cnt_v) + 21'(rad_pkg::HdrLen);
						if (cnt_v == '0) begin
							fire   = 1'b1;
							res_st = rad_pkg::ST_COUNT;
						end else if ({11'd0, dir_end} > total_q) begin
							fire   = 1'b1;
							res_st = rad_pkg::ST_DIR_RANGE;
						end else begin
							das_n      = dir_end;
							largest_n  = {11'd0, dir_end};
							phase_n    = PH_DIR;
							rec_n      = '0;
							pos_n      = '0;
							ofs_n      = '0;
							size_n     = '0;
							name_len_n = '0;
							name_end_n = 1'b0;
							name_bad_n = 1'b0;
						end
					end
				end
				PH_DIR: begin
					if (pos_n < 5'(rad_pkg::NameLen)) begin
						if (!name_end_n) begin
							if (pos_n == 5'(rad_pkg::NameLen - 1) || byte_s1 == 8'd0) begin
								name_end_n = 1'b1;
								if (name_len_n == '0) begin
									name_bad_n = 1'b1;
								end
							end else begin
								if (!rad_pkg::char_ok(byte_s1)) begin
									name_bad_n = 1'b1;
								end
								name_len_n = name_len_n + 4'd1;
							end
						end
					end else if (pos_n < 5'd17) begin
						lane = 2'(pos_n - 5'd13);
						ofs_n[8*lane +: 8] = byte_s1;
					end else begin
						lane = 2'(pos_n - 5'd17);
						size_n[8*lane +: 8] = byte_s1;
					end

					if (pos_n != 5'(rad_pkg::RecLen - 1)) begin
						pos_n = pos_n + 5'd1;
					end else begin
						mem_end = ofs_n + size_n;
						if (ofs_n[31] || size_n[31]) begin
							fire   = 1'b1;
							res_st = rad_pkg::ST_NEGATIVE;
						end else if (name_bad_n) begin
							fire   = 1'b1;
							res_st = rad_pkg::ST_NAME;
						end else if (rec_n == '0 && ofs_n != {11'd0, das_n}) begin
							fire   = 1'b1;
							res_st = rad_pkg::ST_FIRST_OFS;
						end else if (rec_n != '0 && ofs_n < {11'd0, das_n}) begin
							fire   = 1'b1;
							res_st = rad_pkg::ST_OFS_LOW;
						end else if (ofs_n > total_q || size_n > (total_q - ofs_n)) begin
							fire   = 1'b1;
							res_st = rad_pkg::ST_MEMBER_RNG;
						end else begin
							if (mem_end > largest_n) begin
								largest_n = mem_end;
							end
							rec_n      = rec_n + 16'd1;
							pos_n      = '0;
							ofs_n      = '0;
							size_n     = '0;
							name_len_n = '0;
							name_end_n = 1'b0;
							name_bad_n = 1'b0;
							if (rec_n >= count_n) begin
								fire   = 1'b1;
								res_st = rad_pkg::ST_OK;
							end
						end
					end
				end
				default: begin
					fire = 1'b0;
				end
			endcase
		end

		if (fire) begin
			phase_n = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pos_q      <= '0;
			rec_q      <= '0;
			count_q    <= '0;
			das_q      <= '0;
			ofs_q      <= '0;
			size_q     <= '0;
			name_len_q <= '0;
			name_end_q <= 1'b0;
			name_bad_q <= 1'b0;
			largest_q  <= '0;
		end else if (valid_s1 && advance) begin
			phase_q    <= phase_n;
			pos_q      <= pos_n;
			rec_q      <= rec_n;
			count_q    <= count_n;
			das_q      <= das_n;
			ofs_q      <= ofs_n;
			size_q     <= size_n;
			name_len_q <= name_len_n;
			name_end_q <= name_end_n;
			name_bad_q <= name_bad_n;
			largest_q  <= largest_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid <= 1'b0;
		end else if (valid_s1 && advance && fire) begin
			verdict_valid <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && fire) begin
			status          <= res_st;
			archive_size    <= (res_st == rad_pkg::ST_OK) ? largest_n : 32'd0;
			member_count    <= count_n;
			directory_bytes <= rad_pkg::times_rec_len(count_n);
		end
	end

`ifndef SYNTHESIS
	a_size_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && status != rad_pkg::ST_OK |-> archive_size == 32'd0)
		else $error("archive size not zero on a failing verdict");

	a_size_covers_dir: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && status == rad_pkg::ST_OK
		|-> archive_size >= {11'd0, directory_bytes} + 32'd6)
		else $error("archive size below directory end");

	a_dir_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIR |-> count_q != '0 && rec_q < count_q)
		else $error("directory walk with bad record count");

	a_dir_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIR |-> pos_q < 5'(rad_pkg::RecLen))
		else $error("record byte position out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && verdict_valid)
		else $error("byte channel stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ============================================================================
// Resource archive directory check testbench
// Streams archive headers and directory records into the checker: archives
// with random names, offsets and sizes, half of them drawn with a deliberate
// flaw, plus restarts and stray bytes. The expected verdict of each check is
// predicted on every accepted beat and compared field by field with the
// verdict that the checker delivers. Both channels idle and stall at random.
// ============================================================================

module testbench;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_HEADER,
		SCAN_DIRECTORY,
		SCAN_DONE
	} scan_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       sof;
	} archive_beat_t;

	typedef struct packed {
		rad_pkg::status_t status_code;
		logic [31:0]      size;
		logic [15:0]      count;
		logic [20:0]      dir_bytes;
	} verdict_t;

	localparam logic [31:0] ARCHIVE_MAGIC = 32'h4c4d524b;

	localparam int unsigned FLAW_NONE       = 0;
	localparam int unsigned FLAW_FLIP       = 1;
	localparam int unsigned FLAW_SIGN       = 2;
	localparam int unsigned FLAW_BAD_CHAR   = 3;
	localparam int unsigned FLAW_EMPTY_NAME = 4;
	localparam int unsigned FLAW_OFFSET     = 5;
	localparam int unsigned FLAW_RANGE      = 6;
	localparam int unsigned FLAW_TRUNCATE   = 7;
	localparam int unsigned FLAW_MAGIC      = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [31:0] cfg_write_data = '0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = '0;
	logic        start_of_file = 1'b0;
	logic        verdict_valid;
	logic        verdict_stall = 1'b0;
	logic [3:0]  status;
	logic [31:0] archive_size;
	logic [15:0] member_count;
	logic [20:0] directory_bytes;

	archive_beat_t archive_bytes[$];
	verdict_t      expected_verdicts[$];
	archive_beat_t next_beat;
	verdict_t      oldest;
	int unsigned   beats_queued = 0;
	int unsigned   burst_left = 0;
	int unsigned   gap_left = 0;
	logic          beat_held = 1'b0;
	int unsigned   stall_mode = 0;
	int unsigned   stall_tick = 0;
	int            mismatches = 0;

	scan_phase_t scan_phase = SCAN_IDLE;
	logic [31:0] size_limit = '0;
	logic [4:0]  byte_pos = '0;
	logic [15:0] record_no = '0;
	logic [15:0] count_held = '0;
	logic [20:0] area_start = '0;
	logic [31:0] offset_held = '0;
	logic [31:0] size_held = '0;
	logic [3:0]  name_len = '0;
	logic        name_ended = 1'b0;
	logic        name_bad = 1'b0;
	logic [31:0] largest_end = '0;

	resource_archive_directory_check i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.data_byte       (data_byte),
		.start_of_file   (start_of_file),
		.verdict_valid   (verdict_valid),
		.verdict_stall   (verdict_stall),
		.status          (status),
		.archive_size    (archive_size),
		.member_count    (member_count),
		.directory_bytes (directory_bytes)
	);

	always #5 clk = ~clk;

	function automatic logic name_char_ok(input logic [7:0] c);
		if (c < 8'h20 || c > 8'h7e) return 1'b0;
		case (c)
			8'h22, 8'h2a, 8'h2f, 8'h3a, 8'h3c, 8'h3e, 8'h3f, 8'h5c, 8'h7c: return 1'b0;
			default: return 1'b1;
		endcase
	endfunction

	task automatic give_verdict(input rad_pkg::status_t st);
		verdict_t v;
		v.status_code = st;
		v.size = (st == rad_pkg::ST_OK) ? largest_end : 32'd0;
		v.count = count_held;
		v.dir_bytes = 21'(count_held * rad_pkg::RecLen);
		expected_verdicts.push_back(v);
		scan_phase = SCAN_DONE;
	endtask

	task automatic clear_record();
		byte_pos = '0;
		offset_held = '0;
		size_held = '0;
		name_len = '0;
		name_ended = 1'b0;
		name_bad = 1'b0;
	endtask

	task automatic judge_byte(input logic [7:0] b, input logic sof);
		int unsigned dir_end;
		if (sof) begin
			scan_phase = SCAN_HEADER;
			record_no = '0;
			count_held = '0;
			area_start = '0;
			largest_end = '0;
			clear_record();
			if (size_limit < rad_pkg::MinTotal) begin
				give_verdict(rad_pkg::ST_TOO_SMALL);
				return;
			end
		end else if (scan_phase == SCAN_IDLE || scan_phase == SCAN_DONE) begin
			return;
		end
		if (scan_phase == SCAN_HEADER) begin
			if (byte_pos < 4) begin
				if (b != ARCHIVE_MAGIC[8*byte_pos +: 8]) give_verdict(rad_pkg::ST_MAGIC);
				else byte_pos++;
			end else if (byte_pos == 4) begin
				count_held[7:0] = b;
				byte_pos = 5'd5;
			end else begin
				count_held[15:8] = b;
				dir_end = rad_pkg::HdrLen + count_held * rad_pkg::RecLen;
				if (count_held == 0) begin
					give_verdict(rad_pkg::ST_COUNT);
				end else if (dir_end > size_limit) begin
					give_verdict(rad_pkg::ST_DIR_RANGE);
				end else begin
					area_start = dir_end[20:0];
					largest_end = dir_end;
					scan_phase = SCAN_DIRECTORY;
					record_no = '0;
					clear_record();
				end
			end
			return;
		end
		if (byte_pos < rad_pkg::NameLen) begin
			if (!name_ended) begin
				if (byte_pos == rad_pkg::NameLen - 1 || b == 8'h00) begin
					name_ended = 1'b1;
					if (name_len == 0) name_bad = 1'b1;
				end else begin
					if (!name_char_ok(b)) name_bad = 1'b1;
					name_len++;
				end
			end
		end else if (byte_pos < rad_pkg::NameLen + 4) begin
			offset_held[8*(byte_pos - rad_pkg::NameLen) +: 8] = b;
		end else begin
			size_held[8*(byte_pos - rad_pkg::NameLen - 4) +: 8] = b;
		end
		if (byte_pos < rad_pkg::RecLen - 1) begin
			byte_pos++;
			return;
		end
		if (offset_held[31] || size_held[31]) begin
			give_verdict(rad_pkg::ST_NEGATIVE);
		end else if (name_bad) begin
			give_verdict(rad_pkg::ST_NAME);
		end else if (record_no == 0 && offset_held != area_start) begin
			give_verdict(rad_pkg::ST_FIRST_OFS);
		end else if (record_no != 0 && offset_held < area_start) begin
			give_verdict(rad_pkg::ST_OFS_LOW);
		end else if (offset_held > size_limit || size_held > size_limit - offset_held) begin
			give_verdict(rad_pkg::ST_MEMBER_RNG);
		end else begin
			if (offset_held + size_held > largest_end) largest_end = offset_held + size_held;
			record_no++;
			clear_record();
			if (record_no >= count_held) give_verdict(rad_pkg::ST_OK);
		end
	endtask

	task automatic push_beat(input logic [7:0] d, input logic s);
		archive_beat_t x;
		x.data = d;
		x.sof = s;
		archive_bytes.push_back(x);
		beats_queued++;
	endtask

	task automatic push_archive(input logic [31:0] lim);
		logic [7:0]  arc[$];
		logic [7:0]  c;
		int unsigned count, emit, dir_end, upper, room, off, sz, len, target, flaw, pick, last;
		int unsigned i, k;
		if ($urandom_range(0, 15) == 0) begin
			count = $urandom_range(0, 65535);
		end else begin
			count = $urandom_range(1, 4);
			if (lim >= rad_pkg::MinTotal &&
				count > (lim - rad_pkg::HdrLen) / rad_pkg::RecLen)
				count = (lim - rad_pkg::HdrLen) / rad_pkg::RecLen;
		end
		emit = (count > 5) ? 5 : count;
		dir_end = rad_pkg::HdrLen + count * rad_pkg::RecLen;
		upper = (lim > 32'h7fffffff) ? 32'h7fffffff : lim;
		pick = $urandom_range(0, 15);
		flaw = (pick <= FLAW_MAGIC) ? pick : FLAW_NONE;
		target = (emit > 0) ? $urandom_range(0, emit - 1) : 0;
		for (k = 0; k < 4; k++) arc.push_back(ARCHIVE_MAGIC[8*k +: 8]);
		arc.push_back(count[7:0]);
		arc.push_back(count[15:8]);
		for (i = 0; i < emit; i++) begin
			len = $urandom_range(1, 12);
			for (k = 0; k < rad_pkg::NameLen; k++) begin
				if (k < len) begin
					do c = 8'($urandom_range(8'h20, 8'h7e)); while (!name_char_ok(c));
				end else if (k == len && k != rad_pkg::NameLen - 1) begin
					c = 8'h00;
				end else begin
					c = 8'($urandom_range(0, 255));
				end
				arc.push_back(c);
			end
			if (i == target && flaw == FLAW_BAD_CHAR) begin
				pick = $urandom_range(0, 10);
				case (pick)
					0: c = 8'h22;
					1: c = 8'h2a;
					2: c = 8'h3c;
					3: c = 8'h3e;
					4: c = 8'h3f;
					5: c = 8'h7c;
					6: c = 8'h3a;
					7: c = 8'h5c;
					8: c = 8'h2f;
					9: c = 8'($urandom_range(8'h01, 8'h1f));
					default: c = 8'($urandom_range(8'h7f, 8'hff));
				endcase
				arc[arc.size() - rad_pkg::NameLen + $urandom_range(0, len - 1)] = c;
			end
			if (i == target && flaw == FLAW_EMPTY_NAME)
				arc[arc.size() - rad_pkg::NameLen] = 8'h00;
			if (i == 0) begin
				off = dir_end;
			end else if (dir_end <= upper) begin
				room = upper - dir_end;
				if ($urandom_range(0, 3) != 0 && room > 2000) room = 2000;
				off = dir_end + $urandom_range(0, room);
			end else begin
				off = dir_end + $urandom_range(0, 100);
			end
			if (off <= upper) begin
				room = upper - off;
				if ($urandom_range(0, 3) != 0 && room > 3000) room = 3000;
				sz = $urandom_range(0, room);
			end else begin
				sz = $urandom_range(0, 50);
			end
			if (i == target) begin
				case (flaw)
					FLAW_SIGN: begin
						if ($urandom_range(0, 1)) off[31] = 1'b1;
						else sz[31] = 1'b1;
					end
					FLAW_OFFSET: begin
						if (i == 0) off = $urandom_range(0, 1) ? dir_end + 1 : dir_end - 1;
						else off = dir_end - $urandom_range(1, 8);
					end
					FLAW_RANGE: begin
						if ($urandom_range(0, 1)) off = lim + 1;
						else sz = lim - off + $urandom_range(1, 4);
					end
					default: ;
				endcase
			end
			for (k = 0; k < 4; k++) arc.push_back(off[8*k +: 8]);
			for (k = 0; k < 4; k++) arc.push_back(sz[8*k +: 8]);
		end
		last = arc.size();
		case (flaw)
			FLAW_FLIP: arc[$urandom_range(0, arc.size() - 1)] = 8'($urandom_range(0, 255));
			FLAW_MAGIC: arc[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
			FLAW_TRUNCATE: last = $urandom_range(1, arc.size());
			default: ;
		endcase
		for (k = 0; k < last; k++) push_beat(arc[k], k == 0);
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) push_beat(8'($urandom_range(0, 255)), 1'b0);
		if ($urandom_range(0, 15) == 0) push_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic set_size_limit(input logic [31:0] v);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		size_limit = v;
	endtask

	task automatic wait_for_drain();
		while (archive_bytes.size() != 0 || beat_held || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] lim, input int unsigned beats);
		int unsigned goal;
		goal = beats_queued + beats;
		while (beats_queued < goal) push_archive(lim);
		wait_for_drain();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
			beat_held = 1'b0;
		end else begin
			if (byte_valid && !byte_stall) begin
				judge_byte(data_byte, start_of_file);
				beat_held = 1'b0;
			end
			if (!byte_valid || !byte_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					byte_valid <= 1'b0;
				end else if (archive_bytes.size() != 0) begin
					next_beat = archive_bytes.pop_front();
					byte_valid <= 1'b1;
					data_byte <= next_beat.data;
					start_of_file <= next_beat.sof;
					beat_held = 1'b1;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_stall <= 1'b0;
		end else begin
			if (stall_tick == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_tick = $urandom_range(8, 80);
			end else begin
				stall_tick--;
			end
			case (stall_mode)
				0: verdict_stall <= 1'b0;
				1: verdict_stall <= 1'($urandom_range(0, 1));
				2: verdict_stall <= ($urandom_range(0, 7) != 0);
				default: verdict_stall <= stall_tick[1];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && verdict_valid && !verdict_stall) begin
			if (expected_verdicts.size() == 0) begin
				$error("verdict with none expected: status %0d", status);
				mismatches++;
			end else begin
				oldest = expected_verdicts.pop_front();
				if (status !== oldest.status_code) begin
					$error("status: expected %0d, actual %0d", oldest.status_code, status);
					mismatches++;
				end
				if (archive_size !== oldest.size) begin
					$error("archive_size: expected %0d, actual %0d", oldest.size, archive_size);
					mismatches++;
				end
				if (member_count !== oldest.count) begin
					$error("member_count: expected %0d, actual %0d", oldest.count, member_count);
					mismatches++;
				end
				if (directory_bytes !== oldest.dir_bytes) begin
					$error("directory_bytes: expected %0d, actual %0d", oldest.dir_bytes,
						directory_bytes);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes outside a check are ignored; a start below the minimum size fails at once.
		set_size_limit(32'd0);
		push_beat(8'hff, 1'b0);
		push_beat(ARCHIVE_MAGIC[7:0], 1'b1);
		push_beat(ARCHIVE_MAGIC[15:8], 1'b0);
		wait_for_drain();

		set_size_limit(rad_pkg::MinTotal - 1);
		push_beat(ARCHIVE_MAGIC[7:0], 1'b1);
		wait_for_drain();

		set_size_limit(rad_pkg::MinTotal);
		push_beat(8'h00, 1'b1);
		push_beat(ARCHIVE_MAGIC[7:0], 1'b1);
		push_beat(ARCHIVE_MAGIC[15:8], 1'b0);
		push_beat(ARCHIVE_MAGIC[23:16], 1'b0);
		push_beat(8'hff, 1'b0);
		push_beat(ARCHIVE_MAGIC[7:0], 1'b1);
		push_beat(ARCHIVE_MAGIC[15:8], 1'b0);
		for (int n = 0; n < 2; n++) begin
			push_beat(ARCHIVE_MAGIC[7:0], 1'b1);
			push_beat(ARCHIVE_MAGIC[15:8], 1'b0);
			push_beat(ARCHIVE_MAGIC[23:16], 1'b0);
			push_beat(ARCHIVE_MAGIC[31:24], 1'b0);
			push_beat((n == 0) ? 8'h00 : 8'hff, 1'b0);
			push_beat((n == 0) ? 8'h00 : 8'hff, 1'b0);
		end
		run_phase(rad_pkg::MinTotal, 150);

		set_size_limit(32'hffffffff);
		run_phase(32'hffffffff, 150);
		set_size_limit(32'h80000000);
		run_phase(32'h80000000, 150);
		set_size_limit(32'h7fffffff);
		run_phase(32'h7fffffff, 150);
		set_size_limit($urandom_range(rad_pkg::MinTotal + 1, 3000));
		run_phase(size_limit, 150);
		set_size_limit($urandom_range(3000, 32'h7ffffffe));
		run_phase(size_limit, 150);
		set_size_limit($urandom);
		run_phase(size_limit, 150);

		if (mismatches == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ resource_archive_directory_check.f @@
hw/rtl/rad_pkg.sv
hw/rtl/resource_archive_directory_check.sv
verif/testbench.sv
